/* rtl/assert_macros.svh */
// Assertion macros shared by the ordered array RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define OAIDS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define OAIDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define OAIDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/oaids_pkg.sv */
// Types and codes shared by the ordered array modules.
package oaids_pkg;

  localparam int IN_W  = 40;
  localparam int OUT_W = 16;

  typedef enum logic [1:0] {
    MD_SEARCH = 2'd0,
    MD_APPEND = 2'd1,
    MD_INSERT = 2'd2,
    MD_DELETE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Per-item command broadcast to every cell
  typedef struct packed {
    logic app;
    logic ins;
    logic del;
  } cell_ctl_t;

  // Result item, status in the lowest bits
  typedef struct packed {
    logic [4:0] count;
    logic [3:0] found_at;
    status_t    status;
  } res_t;

endpackage

/* rtl/ordered_array_insert_delete_search.sv */
// Top level of the ordered array with insert, delete, append and search.
//
// Usage: items enter on the s_ group (mode, position, value) and results
// leave on the m_ group (status, found_at, count), one result per item,
// in order. Both channels use the tvalid/tready handshake.
// Append, insert and delete update the chain of cells at the edge that
// accepts the item, and their result enters the result queue at that edge;
// a new item may follow in the very next cycle unless the queue is full.
// Search compares every slot at once, then a registered tree picks the
// lowest match: s_tready stays low until the search has passed down the
// tree, so no new item enters before then, and its result enters the
// result queue as it leaves the root. The depth of that tree sets the
// search rate.
// Results go through a two-entry queue; when the receiver stalls, the
// block keeps accepting until the queue is full, then holds s_tready low.
// Reset empties the list and the queue; stored values are undefined until
// written, and no slot at or beyond the count is ever reported.
`include "assert_macros.svh"

module ordered_array_insert_delete_search #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // mode [1:0], position [6:2], value [38:7], zero [39]
  input  logic [oaids_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // status [1:0], found_at [5:2], count [10:6], zero [15:11]
  output logic [oaids_pkg::OUT_W-1:0] m_tdata
);
  import oaids_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LG = $clog2(CAPACITY);
  localparam int EW = (CW > 5) ? CW : 5;
  localparam int FW = (LG > 4) ? LG : 4;

  mode_t         in_mode;
  logic [4:0]    in_pos;
  logic [31:0]   in_val;
  logic          acc;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [EW-1:0] fill_e;
  logic [EW-1:0] pos_e;
  logic [EW-1:0] fn_e;
  logic          full;
  cell_ctl_t     ctl;
  cell_ctl_t     cell_ctl;
  status_t       op_status;
  res_t          op_res;
  res_t          srch_res;
  res_t          push_res;
  logic          push;
  logic          pop;
  logic [LG:0]   tag;
  logic          root_hit;
  logic [LG-1:0] root_idx;
  logic [FW-1:0] root_e;
  logic [CAPACITY-1:0] hit;
  logic [31:0]   ent [0:CAPACITY-1];
  res_t          res_mem [0:1];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;

  // Unpack the input item
  assign in_mode = mode_t'(s_tdata[1:0]);
  assign in_pos  = s_tdata[6:2];
  assign in_val  = s_tdata[38:7];
  assign acc     = s_tvalid && s_tready;

  assign fill_e = EW'(fill);
  assign pos_e  = EW'(in_pos);
  assign full   = (fill == CW'(CAPACITY));

  // Decode the operation and check its bounds
  always_comb begin
    ctl       = '0;
    op_status = ST_OK;
    fill_next = fill;
    unique case (in_mode)
      MD_SEARCH: begin
        op_status = ST_OK;
      end
      MD_APPEND: begin
        if (full) begin
          op_status = ST_FULL;
        end else begin
          ctl.app   = 1'b1;
          fill_next = fill + CW'(1);
        end
      end
      MD_INSERT: begin
        if (pos_e > fill_e) begin
          op_status = ST_BAD_INDEX;
        end else if (full) begin
          op_status = ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          fill_next = fill + CW'(1);
        end
      end
      MD_DELETE: begin
        if (pos_e >= fill_e) begin
          op_status = ST_BAD_INDEX;
        end else begin
          ctl.del   = 1'b1;
          fill_next = fill - CW'(1);
        end
      end
      default: begin
        op_status = ST_BAD_INDEX;
      end
    endcase
  end

  assign cell_ctl = acc ? ctl : '0;

  // Track the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (acc) begin
      fill <= fill_next;
    end
  end

  // Chain of cells, each wired to its neighbors
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [31:0] left;
      logic [31:0] right;
      if (i == 0) begin : g_first
        assign left = in_val;
      end else begin : g_left
        assign left = ent[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right = '0;
      end else begin : g_right
        assign right = ent[i+1];
      end
      oaids_cell #(
        .CW  (CW),
        .IDX (i)
      ) u_cell (
        .clk   (clk),
        .ctl   (cell_ctl),
        .pos   (CW'(in_pos)),
        .fill  (fill),
        .value (in_val),
        .left  (left),
        .right (right),
        .entry (ent[i]),
        .match (hit[i])
      );
    end
  endgenerate

  // Reduce the match flags to the lowest hit
  oaids_find #(
    .N (CAPACITY)
  ) u_find (
    .clk   (clk),
    .hit   (hit),
    .found (root_hit),
    .idx   (root_idx)
  );

  // Follow a search down the tree
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else begin
      tag <= {tag[LG-1:0], acc && (in_mode == MD_SEARCH)};
    end
  end

  // Build the result items
  assign fn_e   = EW'(fill_next);
  assign root_e = FW'(root_idx);

  always_comb begin
    op_res.status   = op_status;
    op_res.found_at = '0;
    op_res.count    = fn_e[4:0];

    srch_res.status   = root_hit ? ST_OK : ST_NOT_FOUND;
    srch_res.found_at = root_hit ? root_e[3:0] : 4'd0;
    srch_res.count    = fill_e[4:0];
  end

  assign push     = tag[LG] || (acc && (in_mode != MD_SEARCH));
  assign push_res = tag[LG] ? srch_res : op_res;
  assign pop      = m_tvalid && m_tready;

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      res_mem[wr_ptr] <= push_res;
    end
  end

  // Result queue pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // Hold input while a search runs or the queue is full
  assign s_tready = !(|tag) && (cnt != 2'd2);
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {5'd0, res_mem[rd_ptr]};

  `OAIDS_ASSERT(a_fill_range, fill <= CW'(CAPACITY), "fill count above capacity")
  `OAIDS_ASSERT(a_one_search, $onehot0(tag), "more than one search in flight")
  `OAIDS_ASSERT_IMP(a_search_room, tag[LG], cnt != 2'd2, "search done with result queue full")
  `OAIDS_ASSERT_NXT(a_del_count, cell_ctl.del, fill == $past(fill) - CW'(1), "delete count slip")

endmodule

/* rtl/oaids_cell.sv */
// One slot of the ordered array: holds an entry, shifts with its neighbors, compares the key.
module oaids_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  oaids_pkg::cell_ctl_t  ctl,
  input  logic [CW-1:0]         pos,
  input  logic [CW-1:0]         fill,
  input  logic [31:0]           value,
  input  logic [31:0]           left,
  input  logic [31:0]           right,
  output logic [31:0]           entry,
  output logic                  match
);
  import oaids_pkg::*;

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

  // Load, shift in from a neighbor, or hold
  always_ff @(posedge clk) begin
    if (ctl.app && (IDX_C == fill)) begin
      entry <= value;
    end else if (ctl.ins && (IDX_C == pos)) begin
      entry <= value;
    end else if (ctl.ins && (IDX_C > pos) && (IDX_C <= fill)) begin
      entry <= left;
    end else if (ctl.del && (IDX_C >= pos) && (IDX_P1 < fill)) begin
      entry <= right;
    end
  end

  // Flag an occupied slot that equals the key
  assign match = (entry == value) && (IDX_C < fill);

endmodule

/* rtl/oaids_find.sv */
// Registered reduction tree that finds the lowest flagged slot.
module oaids_find #(
  parameter int N = 16,
  localparam int LG = $clog2(N)
) (
  input  logic          clk,
  input  logic [N-1:0]  hit,
  output logic          found,
  output logic [LG-1:0] idx
);
  import oaids_pkg::*;

  localparam int N2 = 1 << LG;

  logic          lv_hit [0:LG][0:N2-1];
  logic [LG-1:0] lv_idx [0:LG][0:N2-1];

  genvar l, n;
  generate
    // Capture the match flags, pad the unused leaves
    for (n = 0; n < N2; n++) begin : g_leaf
      if (n < N) begin : g_used
        always_ff @(posedge clk) begin
          lv_hit[0][n] <= hit[n];
          lv_idx[0][n] <= LG'(n);
        end
      end else begin : g_pad
        always_ff @(posedge clk) begin
          lv_hit[0][n] <= 1'b0;
          lv_idx[0][n] <= LG'(n);
        end
      end
    end

    // Merge pairs, the lower slot wins
    for (l = 1; l <= LG; l++) begin : g_lvl
      for (n = 0; n < N2; n++) begin : g_node
        if (n < (N2 >> l)) begin : g_used
          always_ff @(posedge clk) begin
            lv_hit[l][n] <= lv_hit[l-1][2*n] | lv_hit[l-1][2*n+1];
            lv_idx[l][n] <= lv_hit[l-1][2*n] ? lv_idx[l-1][2*n] : lv_idx[l-1][2*n+1];
          end
        end else begin : g_pad
          always_ff @(posedge clk) begin
            lv_hit[l][n] <= 1'b0;
            lv_idx[l][n] <= '0;
          end
        end
      end
    end
  endgenerate

  assign found = lv_hit[LG][0];
  assign idx   = lv_idx[LG][0];

endmodule
